// File: hdl/pdf_pkg.sv
// Shared types and constants for the PES packet deframer.
`timescale 1ns / 1ps
package pdf_pkg;

  localparam int unsigned POS_W = 17;

  localparam logic [POS_W-1:0] POS_START2    = 17'd2;
  localparam logic [POS_W-1:0] POS_ID        = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD   = 17'd6;
  localparam logic [POS_W-1:0] LEN_EXTRA     = 17'd6;

  localparam logic [7:0] START_BYTE_ZERO = 8'h00;
  localparam logic [7:0] START_BYTE_ONE  = 8'h01;

  localparam logic REG_STREAM_ID      = 1'b0;
  localparam logic REG_STREAM_ID_MASK = 1'b1;

  typedef struct packed {
    logic       hdr;
    logic [7:0] data;
    logic       last;
  } q_entry_t;

  typedef enum logic [1:0] {
    BEAT_SC0,
    BEAT_SC1,
    BEAT_SC2,
    BEAT_ID
  } beat_t;

endpackage

// File: hdl/pdf_front.sv
// Front end: configuration registers, start code hunt and packet byte classification.
`timescale 1ns / 1ps
module pdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [7:0]          in_data_byte,
  output logic                q_wr,
  output pdf_pkg::q_entry_t   q_wr_entry
);

  logic [7:0]                  sid_r;
  logic [7:0]                  mask_r;
  logic [pdf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [pdf_pkg::POS_W-1:0]   len_r, len_nxt;
  logic [7:0]                  hi_r, hi_nxt;
  logic [7:0]                  masked;
  logic [pdf_pkg::POS_W-1:0]   pos_inc;
  logic                        emit;
  pdf_pkg::q_entry_t           ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid_r  <= 8'h00;
      mask_r <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        pdf_pkg::REG_STREAM_ID:      sid_r  <= cfg_data;
        pdf_pkg::REG_STREAM_ID_MASK: mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign masked  = in_data_byte & mask_r;
  assign pos_inc = pos_r + 17'd1;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    hi_nxt   = hi_r;
    emit     = 1'b0;
    ent.hdr  = 1'b0;
    ent.data = in_data_byte;
    ent.last = 1'b0;
    if (pos_r < pdf_pkg::POS_ID) begin
      if (in_data_byte == ((pos_r == pdf_pkg::POS_START2) ? pdf_pkg::START_BYTE_ONE
                                                          : pdf_pkg::START_BYTE_ZERO)) begin
        pos_nxt = pos_inc;
      end else begin
        pos_nxt = (in_data_byte == pdf_pkg::START_BYTE_ZERO) ? pdf_pkg::POS_START2 : '0;
      end
    end else if (pos_r == pdf_pkg::POS_ID) begin
      if (masked != sid_r) begin
        pos_nxt = (masked == pdf_pkg::START_BYTE_ZERO) ? pdf_pkg::POS_START2 : '0;
      end else begin
        emit    = 1'b1;
        ent.hdr = 1'b1;
        pos_nxt = pdf_pkg::POS_LEN_HI;
      end
    end else if (pos_r == pdf_pkg::POS_LEN_HI) begin
      hi_nxt  = in_data_byte;
      emit    = 1'b1;
      pos_nxt = pdf_pkg::POS_LEN_LO;
    end else if (pos_r == pdf_pkg::POS_LEN_LO) begin
      len_nxt = {1'b0, hi_r, in_data_byte} + pdf_pkg::LEN_EXTRA;
      emit    = 1'b1;
      if ({hi_r, in_data_byte} == 16'h0000) begin
        ent.last = 1'b1;
        pos_nxt  = '0;
      end else begin
        pos_nxt  = pdf_pkg::POS_PAYLOAD;
      end
    end else begin
      emit = 1'b1;
      if (pos_inc >= len_r) begin
        ent.last = 1'b1;
        pos_nxt  = '0;
      end else begin
        pos_nxt  = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      hi_r  <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      hi_r  <= hi_nxt;
    end
  end

  assign q_wr       = accept & emit;
  assign q_wr_entry = ent;

endmodule

// File: hdl/pdf_queue.sv
// Short request queue between the classifier and the output sequencer.
`timescale 1ns / 1ps
module pdf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  pdf_pkg::q_entry_t  wr_entry,
  input  logic               rd,
  output pdf_pkg::q_entry_t  head,
  output logic               q_empty,
  output logic               q_full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pdf_pkg::q_entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_wr, do_rd;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CNT_FULL);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/pdf_back.sv
// Back end: expands queued requests into result bytes held in an output register.
`timescale 1ns / 1ps
module pdf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pdf_pkg::q_entry_t  head,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               out_first_of_packet,
  output logic               out_last_of_packet,
  output logic               out_run_last
);

  pdf_pkg::beat_t  beat_r, beat_nxt;
  logic            valid_r;
  logic [7:0]      byte_r;
  logic            first_r, last_r, run_last_r;
  logic            load, take;
  logic [7:0]      byte_c;
  logic            first_c, last_c, run_last_c;

  assign load = ~valid_r | pop;
  assign take = load & ~q_empty;

  always_comb begin
    beat_nxt = beat_r;
    if (take && head.hdr) begin
      case (beat_r)
        pdf_pkg::BEAT_SC0: beat_nxt = pdf_pkg::BEAT_SC1;
        pdf_pkg::BEAT_SC1: beat_nxt = pdf_pkg::BEAT_SC2;
        pdf_pkg::BEAT_SC2: beat_nxt = pdf_pkg::BEAT_ID;
        pdf_pkg::BEAT_ID:  beat_nxt = pdf_pkg::BEAT_SC0;
        default:           beat_nxt = pdf_pkg::BEAT_SC0;
      endcase
    end
  end

  always_comb begin
    byte_c     = head.data;
    first_c    = 1'b0;
    last_c     = 1'b0;
    run_last_c = 1'b1;
    q_rd       = take;
    if (head.hdr) begin
      run_last_c = 1'b0;
      q_rd       = 1'b0;
      case (beat_r)
        pdf_pkg::BEAT_SC0: begin
          byte_c  = pdf_pkg::START_BYTE_ZERO;
          first_c = 1'b1;
        end
        pdf_pkg::BEAT_SC1: byte_c = pdf_pkg::START_BYTE_ZERO;
        pdf_pkg::BEAT_SC2: byte_c = pdf_pkg::START_BYTE_ONE;
        pdf_pkg::BEAT_ID: begin
          run_last_c = 1'b1;
          q_rd       = take;
        end
        default: ;
      endcase
    end else begin
      last_c = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= pdf_pkg::BEAT_SC0;
      valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        valid_r <= ~q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r     <= byte_c;
      first_r    <= first_c;
      last_r     <= last_c;
      run_last_r <= run_last_c;
    end
  end

  assign empty               = ~valid_r;
  assign out_byte            = byte_r;
  assign out_first_of_packet = first_r;
  assign out_last_of_packet  = last_r;
  assign out_run_last        = run_last_r;

`ifndef NO_ASSERTIONS
  a_first_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && first_r |-> byte_r == pdf_pkg::START_BYTE_ZERO && !run_last_r && !last_r)
    else $error("first byte of packet is not a start code zero");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && last_r |-> run_last_r)
    else $error("packet end without run end");
  a_beat_on_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != pdf_pkg::BEAT_SC0 |-> !q_empty && head.hdr)
    else $error("header expansion without header request at queue head");
  a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> beat_r == $past(beat_r))
    else $error("header beat moved without loading a result");
`endif

endmodule

// File: hdl/pes_packet_deframer.sv
// Top level of the PES packet deframer.
`timescale 1ns / 1ps
// Accepts one stream byte per cycle while full is low and hunts for the start code
// 00 00 01 plus a stream id that matches stream_id under stream_id_mask. A matching
// header comes out as four result bytes (first_of_packet on the first), then every
// packet byte up to the length field plus six, the final one marked last_of_packet;
// run_last marks the last result of each input byte. Hunting bytes give no result. A
// header byte expands into four results through the single-result output register;
// the QUEUE_DEPTH-entry request queue absorbs those bursts. full follows that queue.
module pes_packet_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic        out_run_last
);

  logic               accept;
  logic               q_wr, q_rd, q_empty;
  pdf_pkg::q_entry_t  q_wr_entry, q_head;

  assign accept = push & ~full;

  pdf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .in_data_byte (in_data_byte),
    .q_wr         (q_wr),
    .q_wr_entry   (q_wr_entry)
  );

  pdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_entry (q_wr_entry),
    .rd       (q_rd),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_full   (full)
  );

  pdf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .head                (q_head),
    .q_rd                (q_rd),
    .pop                 (pop),
    .empty               (empty),
    .out_byte            (out_byte),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_run_last        (out_run_last)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the PES packet deframer: byte stream in, framed packet bytes out.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_last;
  } pes_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = pdf_pkg::REG_STREAM_ID;
  logic [7:0] cfg_data = 8'h00;
  logic       push = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_first_of_packet;
  logic       out_last_of_packet;
  logic       out_run_last;

  always #5 clk = ~clk;

  pes_packet_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .push                (push),
    .full                (full),
    .in_data_byte        (in_data_byte),
    .empty               (empty),
    .pop                 (pop),
    .out_byte            (out_byte),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_run_last        (out_run_last)
  );

  // deframer state as predicted
  logic [pdf_pkg::POS_W-1:0] frame_pos = '0;
  logic [pdf_pkg::POS_W-1:0] frame_len = '0;
  logic [7:0]       len_hi = 8'h00;
  logic [7:0]       cur_id = 8'h00;
  logic [7:0]       cur_mask = 8'hFF;

  pes_beat_t   beats_due[$];
  logic [7:0]  bytes_todo[$];
  pes_beat_t   want_beat;
  pes_beat_t   got_beat;
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_pkts = 0;
  int unsigned n_err = 0;
  int          pace = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic int idle_pct(input bit sender);
    case (pace)
      0: return sender ? 11 : 63;
      1: return sender ? 63 : 11;
      default: return 0;
    endcase
  endfunction

  task automatic expect_beat(input logic [7:0] d, input logic f, input logic l,
                             input logic r);
    beats_due.push_back({d, f, l, r});
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [7:0]       masked;
    logic [pdf_pkg::POS_W-1:0] nxt;
    masked = b & cur_mask;
    if (frame_pos < pdf_pkg::POS_ID) begin
      if (b == ((frame_pos == pdf_pkg::POS_START2) ? pdf_pkg::START_BYTE_ONE
                                                   : pdf_pkg::START_BYTE_ZERO))
        frame_pos = frame_pos + 1'b1;
      else
        frame_pos = (b == pdf_pkg::START_BYTE_ZERO) ? pdf_pkg::POS_START2 : '0;
    end else if (frame_pos == pdf_pkg::POS_ID) begin
      if (masked != cur_id) begin
        frame_pos = (masked == 8'h00) ? pdf_pkg::POS_START2 : '0;
      end else begin
        expect_beat(pdf_pkg::START_BYTE_ZERO, 1'b1, 1'b0, 1'b0);
        expect_beat(pdf_pkg::START_BYTE_ZERO, 1'b0, 1'b0, 1'b0);
        expect_beat(pdf_pkg::START_BYTE_ONE, 1'b0, 1'b0, 1'b0);
        expect_beat(b, 1'b0, 1'b0, 1'b1);
        frame_pos = pdf_pkg::POS_LEN_HI;
      end
    end else if (frame_pos == pdf_pkg::POS_LEN_HI) begin
      len_hi = b;
      expect_beat(b, 1'b0, 1'b0, 1'b1);
      frame_pos = pdf_pkg::POS_LEN_LO;
    end else if (frame_pos == pdf_pkg::POS_LEN_LO) begin
      frame_len = {1'b0, len_hi, b} + pdf_pkg::LEN_EXTRA;
      if (frame_len <= pdf_pkg::LEN_EXTRA) begin
        expect_beat(b, 1'b0, 1'b1, 1'b1);
        frame_pos = '0;
      end else begin
        expect_beat(b, 1'b0, 1'b0, 1'b1);
        frame_pos = pdf_pkg::POS_PAYLOAD;
      end
    end else begin
      nxt = frame_pos + 1'b1;
      if (nxt >= frame_len) begin
        expect_beat(b, 1'b0, 1'b1, 1'b1);
        frame_pos = '0;
      end else begin
        expect_beat(b, 1'b0, 1'b0, 1'b1);
        frame_pos = nxt;
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        predict_byte(in_data_byte);
        n_sent <= n_sent + 1;
      end
      if (bytes_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        push <= 1'b1;
        in_data_byte <= bytes_todo.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // hold off the output once for a long stretch while requests keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && pace == 2 && push) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_beat = {out_byte, out_first_of_packet, out_last_of_packet, out_run_last};
        n_got = n_got + 1;
        if (out_last_of_packet) n_pkts = n_pkts + 1;
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected result byte %02h first %0b last %0b run_last %0b",
                   $time, got_beat.data, got_beat.first, got_beat.last, got_beat.run_last);
          n_err = n_err + 1;
        end else begin
          want_beat = beats_due.pop_front();
          if (got_beat !== want_beat) begin
            $display("%0t: mismatch, expected byte %02h first %0b last %0b run_last %0b",
                     $time, want_beat.data, want_beat.first, want_beat.last,
                     want_beat.run_last);
            $display("%0t:           actual   byte %02h first %0b last %0b run_last %0b",
                     $time, got_beat.data, got_beat.first, got_beat.last,
                     got_beat.run_last);
            n_err = n_err + 1;
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  task automatic add_byte(input logic [7:0] b);
    bytes_todo.push_back(b);
    n_queued = n_queued + 1;
  endtask

  // queue the low n bytes of seq, most significant first
  task automatic add_run(input logic [255:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(seq[8*i +: 8]);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == pdf_pkg::REG_STREAM_ID) cur_id = val;
    else cur_mask = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    while (bytes_todo.size() != 0 || push || beats_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic gen_traffic(input int unsigned target);
    int unsigned stop_at;
    int          kind;
    int          len;
    logic [7:0]  low_bit;
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        add_run(24'h000001, 3);
        if ($urandom_range(0, 99) < 85)
          add_byte((cur_id & cur_mask) | (8'($urandom) & ~cur_mask));
        else
          add_byte(8'($urandom));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        add_run(16'(len), 2);
        repeat (len) add_byte(8'($urandom));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 3)) add_byte(pdf_pkg::START_BYTE_ZERO);
        add_byte(8'($urandom_range(2, 255)));
      end else if (kind < 88 && cur_mask != 8'h00) begin
        low_bit = cur_mask & (~cur_mask + 8'h01);
        add_run(24'h000001, 3);
        add_byte((cur_id & cur_mask) ^ low_bit);
      end else begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'hE0);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'hF0);
        end
        1: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'hBD);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'hFF);
        end
        2: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'h00);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'h00);
        end
        3: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'hFF);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'hFF);
        end
        4: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'h05);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'h07);
        end
        default: begin
          write_reg(pdf_pkg::REG_STREAM_ID, 8'h00);
          write_reg(pdf_pkg::REG_STREAM_ID_MASK, 8'hFF);
        end
      endcase
      pace <= ph / 2;
      case (ph)
        0: begin
          add_run(48'h000001E50000, 6);
          add_run(64'h00000001E00001AA, 8);
          add_run(32'h000001C3, 4);
          add_run(80'h0000010F01EF0002FF00, 10);
          gen_traffic(40);
          add_run(56'h000001E0000311, 7);
        end
        1: begin
          add_run(16'h2233, 2);
          gen_traffic(40);
          add_run(24'h000001, 3);
        end
        2: begin
          add_run(32'h4700015A, 4);
          gen_traffic(40);
        end
        5: begin
          gen_traffic(40);
          add_run(48'h00000100FFFF, 6);
          repeat (40) add_byte(8'($urandom));
        end
        default: gen_traffic(40);
      endcase
    end
    settle();
    $display("summary: %0d bytes in, %0d result bytes checked, %0d packets closed",
             n_sent, n_got, n_pkts);
    $display("summary: six id/mask settings, split packets, a long open packet, output stall");
    if (n_err == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", beats_due.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
